[rtl/itr_pkg.sv]
`timescale 1ns / 1ps

package itr_pkg;

   // Largest value that has a numeral
   localparam logic [11:0] MAX_VALUE = 12'd3999;

   // Queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_AW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

   // ASCII codes of the numeral letters
   localparam logic [7:0] CH_I       = 8'h49;
   localparam logic [7:0] CH_V       = 8'h56;
   localparam logic [7:0] CH_X       = 8'h58;
   localparam logic [7:0] CH_L       = 8'h4C;
   localparam logic [7:0] CH_C       = 8'h43;
   localparam logic [7:0] CH_D       = 8'h44;
   localparam logic [7:0] CH_M       = 8'h4D;
   localparam logic [7:0] ERR_SYMBOL = 8'h00;

   // Decimal places
   localparam logic [1:0] PLACE_UNIT = 2'd0;
   localparam logic [1:0] PLACE_TENS = 2'd1;
   localparam logic [1:0] PLACE_HUND = 2'd2;
   localparam logic [1:0] PLACE_THOU = 2'd3;

   // Rows of the digit step table
   localparam logic [1:0] ROW_THOU = 2'd0;
   localparam logic [1:0] ROW_HUND = 2'd1;
   localparam logic [1:0] ROW_TENS = 2'd2;

   // Multiples of each place weight, digit 0 to 9
   localparam logic [13:0] STEP_TABLE [0:2][0:9] = '{
      '{14'd0, 14'd1000, 14'd2000, 14'd3000, 14'd4000,
        14'd5000, 14'd6000, 14'd7000, 14'd8000, 14'd9000},
      '{14'd0, 14'd100, 14'd200, 14'd300, 14'd400,
        14'd500, 14'd600, 14'd700, 14'd800, 14'd900},
      '{14'd0, 14'd10, 14'd20, 14'd30, 14'd40,
        14'd50, 14'd60, 14'd70, 14'd80, 14'd90}
   };

   // One classified number as it waits in the queue
   typedef struct packed {
      logic       err;
      logic [1:0] thou;
      logic [3:0] hund;
      logic [3:0] tens;
      logic [3:0] unit;
   } itr_entry_type;

   // Queue status; the back end sees both flags, the front end the full flag
   typedef struct packed {
      logic full;
      logic empty;
   } itr_qstat_type;

   // Result of one digit extraction step
   typedef struct packed {
      logic [3:0]  digit;
      logic [11:0] rem;
   } itr_step_type;

   typedef enum logic [2:0] {
      FE_IDLE,
      FE_THOU,
      FE_HUND,
      FE_TENS,
      FE_PUSH
   } itr_fe_state_type;

   // Which letter of a place a character uses
   typedef enum logic [1:0] {
      SEL_ONE,
      SEL_FIVE,
      SEL_TEN
   } itr_sel_type;

   // Peel one decimal digit off rem by parallel compares against its multiples
   function automatic itr_step_type step_digit(input logic [11:0] rem,
                                               input logic [1:0]  row);
      itr_step_type r;
      logic [13:0]  sub;
      r.digit = '0;
      sub     = '0;
      for (int k = 1; k < 10; k++) begin
         if ({2'b00, rem} >= STEP_TABLE[row][k]) begin
            r.digit = 4'(k);
            sub     = STEP_TABLE[row][k];
         end
      end
      r.rem = 12'({2'b00, rem} - sub);
      return r;
   endfunction

   // Number of characters a digit takes
   function automatic logic [2:0] digit_len(input logic [3:0] d);
      logic [2:0] n;
      unique case (d)
         4'd0:                      n = 3'd0;
         4'd1, 4'd5:                n = 3'd1;
         4'd2, 4'd4, 4'd6, 4'd9:    n = 3'd2;
         4'd3, 4'd7:                n = 3'd3;
         4'd8:                      n = 3'd4;
         default:                   n = 3'd0;
      endcase
      return n;
   endfunction

   // Letter kind at position i of a digit
   function automatic itr_sel_type digit_sel(input logic [3:0] d, input logic [1:0] i);
      itr_sel_type s;
      if (d == 4'd9) begin
         s = (i == 2'd0) ? SEL_ONE : SEL_TEN;
      end else if (d == 4'd4) begin
         s = (i == 2'd0) ? SEL_ONE : SEL_FIVE;
      end else if (d >= 4'd5) begin
         s = (i == 2'd0) ? SEL_FIVE : SEL_ONE;
      end else begin
         s = SEL_ONE;
      end
      return s;
   endfunction

   // ASCII letter for a place and letter kind
   function automatic logic [7:0] place_char(input logic [1:0] place, input itr_sel_type s);
      logic [7:0] c;
      c = CH_M;
      unique case (place)
         PLACE_UNIT: c = (s == SEL_ONE) ? CH_I : (s == SEL_FIVE) ? CH_V : CH_X;
         PLACE_TENS: c = (s == SEL_ONE) ? CH_X : (s == SEL_FIVE) ? CH_L : CH_C;
         PLACE_HUND: c = (s == SEL_ONE) ? CH_C : (s == SEL_FIVE) ? CH_D : CH_M;
         PLACE_THOU: c = CH_M;
         default:    c = CH_M;
      endcase
      return c;
   endfunction

endpackage

[rtl/itr_front.sv]
`timescale 1ns / 1ps

module itr_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  logic [11:0]            req_value,
   output logic                   push_valid,
   output itr_pkg::itr_entry_type push_entry,
   input  logic                   queue_full
);
   import itr_pkg::*;

   itr_fe_state_type state_ff, state_in;
   logic [11:0]      rem_ff, rem_in;
   itr_entry_type    entry_ff, entry_in;
   itr_step_type     step;

   // Hold state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FE_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      rem_ff   <= rem_in;
      entry_ff <= entry_in;
   end

   // Classify the transaction, then peel digits one place per cycle
   always_comb begin
      state_in   = state_ff;
      rem_in     = rem_ff;
      entry_in   = entry_ff;
      step       = '0;
      busy       = (state_ff != FE_IDLE);
      push_valid = 1'b0;
      unique case (state_ff)
         FE_IDLE: begin
            if (start) begin
               if (req_value > MAX_VALUE) begin
                  entry_in     = '0;
                  entry_in.err = 1'b1;
                  state_in     = FE_PUSH;
               end else if (req_value != 12'd0) begin
                  entry_in = '0;
                  rem_in   = req_value;
                  state_in = FE_THOU;
               end
            end
         end
         FE_THOU: begin
            step          = step_digit(rem_ff, ROW_THOU);
            entry_in.thou = step.digit[1:0];
            rem_in        = step.rem;
            state_in      = FE_HUND;
         end
         FE_HUND: begin
            step          = step_digit(rem_ff, ROW_HUND);
            entry_in.hund = step.digit;
            rem_in        = step.rem;
            state_in      = FE_TENS;
         end
         FE_TENS: begin
            step          = step_digit(rem_ff, ROW_TENS);
            entry_in.tens = step.digit;
            entry_in.unit = step.rem[3:0];
            rem_in        = step.rem;
            state_in      = FE_PUSH;
         end
         FE_PUSH: begin
            push_valid = 1'b1;
            if (!queue_full) begin
               state_in = FE_IDLE;
            end
         end
         default: state_in = FE_IDLE;
      endcase
   end

   assign push_entry = entry_ff;

endmodule

[rtl/itr_queue.sv]
`timescale 1ns / 1ps

module itr_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  itr_pkg::itr_entry_type push_entry,
   input  logic                   pop,
   output itr_pkg::itr_entry_type head,
   output itr_pkg::itr_qstat_type status
);
   import itr_pkg::*;

   itr_entry_type       mem_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_AW:0]   count_ff, count_in;
   logic                push_fire, pop_fire;

   assign status.full  = (count_ff == (QUEUE_AW+1)'(QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);
   assign push_fire    = push && !status.full;
   assign pop_fire     = pop && !status.empty;
   assign head         = mem_ff[rd_ptr_ff];

   // Advance pointers and count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_fire) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop_fire) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push_fire && !pop_fire) begin
         count_in = count_ff + 1'b1;
      end else if (pop_fire && !push_fire) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store entries
   always_ff @(posedge clock) begin
      if (push_fire) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

[rtl/itr_back.sv]
`timescale 1ns / 1ps

module itr_back (
   input  logic                   clock,
   input  logic                   reset,
   input  itr_pkg::itr_entry_type head,
   input  itr_pkg::itr_qstat_type status,
   output logic                   pop,
   output logic                   rsp_valid,
   output logic [7:0]             rsp_symbol,
   output logic                   rsp_last,
   output logic                   rsp_out_of_range
);
   import itr_pkg::*;

   logic          active_ff, active_in;
   itr_entry_type cur_ff, cur_in;
   logic [1:0]    place_ff, place_in;
   logic [1:0]    idx_ff, idx_in;
   logic          valid_ff, valid_in;
   logic [7:0]    symbol_ff, symbol_in;
   logic          last_ff, last_in;
   logic          oor_ff, oor_in;

   logic [3:0]    digit;
   logic [2:0]    len;
   logic          lower_zero;
   logic          at_end;
   logic          is_last;

   // Pick the digit of the current place
   always_comb begin
      digit      = cur_ff.unit;
      lower_zero = 1'b1;
      unique case (place_ff)
         PLACE_THOU: begin
            digit      = {2'b00, cur_ff.thou};
            lower_zero = (cur_ff.hund == 4'd0) && (cur_ff.tens == 4'd0)
                         && (cur_ff.unit == 4'd0);
         end
         PLACE_HUND: begin
            digit      = cur_ff.hund;
            lower_zero = (cur_ff.tens == 4'd0) && (cur_ff.unit == 4'd0);
         end
         PLACE_TENS: begin
            digit      = cur_ff.tens;
            lower_zero = (cur_ff.unit == 4'd0);
         end
         PLACE_UNIT: begin
            digit      = cur_ff.unit;
            lower_zero = 1'b1;
         end
         default: begin
            digit      = cur_ff.unit;
            lower_zero = 1'b1;
         end
      endcase
      len     = digit_len(digit);
      at_end  = (({1'b0, idx_ff} + 3'd1) == len);
      is_last = at_end && lower_zero;
   end

   // Pop an entry when free, then emit one character per cycle, but none while a zero digit is skipped
   always_comb begin
      active_in = active_ff;
      cur_in    = cur_ff;
      place_in  = place_ff;
      idx_in    = idx_ff;
      valid_in  = 1'b0;
      symbol_in = symbol_ff;
      last_in   = last_ff;
      oor_in    = oor_ff;
      pop       = 1'b0;
      if (!active_ff) begin
         if (!status.empty) begin
            pop       = 1'b1;
            cur_in    = head;
            place_in  = PLACE_THOU;
            idx_in    = 2'd0;
            active_in = 1'b1;
         end
      end else if (cur_ff.err) begin
         valid_in  = 1'b1;
         symbol_in = ERR_SYMBOL;
         last_in   = 1'b1;
         oor_in    = 1'b1;
         active_in = 1'b0;
      end else if (len == 3'd0) begin
         // skip a zero digit
         idx_in = 2'd0;
         if (place_ff == PLACE_UNIT) begin
            active_in = 1'b0;
         end else begin
            place_in = place_ff - 1'b1;
         end
      end else begin
         valid_in  = 1'b1;
         symbol_in = place_char(place_ff, digit_sel(digit, idx_ff));
         last_in   = is_last;
         oor_in    = 1'b0;
         if (!at_end) begin
            idx_in = idx_ff + 1'b1;
         end else begin
            idx_in = 2'd0;
            if (is_last || place_ff == PLACE_UNIT) begin
               active_in = 1'b0;
            end else begin
               place_in = place_ff - 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         valid_ff  <= 1'b0;
      end else begin
         active_ff <= active_in;
         valid_ff  <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff    <= cur_in;
      place_ff  <= place_in;
      idx_ff    <= idx_in;
      symbol_ff <= symbol_in;
      last_ff   <= last_in;
      oor_ff    <= oor_in;
   end

   assign rsp_valid        = valid_ff;
   assign rsp_symbol       = symbol_ff;
   assign rsp_last         = last_ff;
   assign rsp_out_of_range = oor_ff;

endmodule

[rtl/integer_to_roman_numeral.sv]
`timescale 1ns / 1ps

// Converts a 12-bit unsigned value into its Roman numeral, one ASCII character per
// rsp_valid strobe, thousands first, rsp_last on the final character. Pulse start
// with req_value while busy is low; zero yields no characters and a value above 3999
// yields a single strobe with rsp_out_of_range and rsp_last set and symbol 0. The
// strobe cannot be held off, so the receiver must take every character on the cycle
// it appears. The front end keeps busy high after each value from 1 to 3999 while
// it runs three digit-extraction steps and a push into a two-entry queue, and
// after a value above 3999 for the push alone, longer if the queue is full; a zero
// value leaves busy low. The back end pops a number, then emits its characters in
// turn and skips each zero digit ahead of the final character (the longest numeral,
// MMMDCCCLXXXVIII, is 15 characters); the slower of the two ends sets the
// sustained rate. Its first character leaves the output registers after the pop
// loads the entry and any leading zero digits are skipped.
module integer_to_roman_numeral (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [11:0] req_value,
   output logic        rsp_valid,
   output logic [7:0]  rsp_symbol,
   output logic        rsp_last,
   output logic        rsp_out_of_range
);
   import itr_pkg::*;

   logic          push_valid;
   itr_entry_type push_entry;
   itr_entry_type head;
   itr_qstat_type qstat;
   logic          pop;

   itr_front u_front (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_value  (req_value),
      .push_valid (push_valid),
      .push_entry (push_entry),
      .queue_full (qstat.full)
   );

   itr_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push_valid),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .status     (qstat)
   );

   itr_back u_back (
      .clock            (clock),
      .reset            (reset),
      .head             (head),
      .status           (qstat),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_symbol       (rsp_symbol),
      .rsp_last         (rsp_last),
      .rsp_out_of_range (rsp_out_of_range)
   );

   // An error transaction is one terminal character with a null symbol
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_out_of_range |-> rsp_last && (rsp_symbol == ERR_SYMBOL))
      else $error("out-of-range result malformed");

   // Normal characters are numeral letters only
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_out_of_range |->
         (rsp_symbol == CH_I) || (rsp_symbol == CH_V) || (rsp_symbol == CH_X) ||
         (rsp_symbol == CH_L) || (rsp_symbol == CH_C) || (rsp_symbol == CH_D) ||
         (rsp_symbol == CH_M))
      else $error("symbol is not a numeral letter");

   // A zero value leaves the front end free on the next cycle
   assert property (@(posedge clock) disable iff (reset)
      start && !busy && (req_value == 12'd0) |=> !busy)
      else $error("zero value made the front end busy");

   // The queue is never both full and empty
   assert property (@(posedge clock) disable iff (reset)
      !(qstat.full && qstat.empty))
      else $error("queue status inconsistent");

   // Popping only happens from a non-empty queue
   assert property (@(posedge clock) disable iff (reset)
      pop |-> !qstat.empty)
      else $error("pop from empty queue");

endmodule
